// ===== rtl/rdat_pkg.sv =====
// Package for the ray and disc acceptance test: formats, CORDIC constants, register codes.
`default_nettype none
package rdat_pkg;

  localparam int LEN_W        = 32;
  localparam int RAD_W        = 31;
  localparam int POLAR_W      = 15;
  localparam int AZIM_W       = 16;
  localparam int ANG_OUT_W    = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int TAB_LEN      = 30;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd3;

  // CORDIC gain compensation, Q30 for sin/cos and Q22 for the magnitude.
  localparam logic [31:0] K30 = 32'd652032874;
  localparam logic [21:0] K22 = 22'd2547003;

  // atan(2^-i) with a full turn equal to 2^32.
  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
    32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

endpackage
`default_nettype wire

// ===== rtl/rdat_ifs.sv =====
// Handshake channel interfaces for the input, result and configuration words.
`default_nettype none
interface rdat_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rdat_pkg::LEN_W-1:0]     source_x;
  logic signed [rdat_pkg::LEN_W-1:0]     source_y;
  logic        [rdat_pkg::POLAR_W-1:0]   polar_angle;
  logic        [rdat_pkg::AZIM_W-1:0]    azimuth_angle;
  modport source (output valid, source_x, source_y, polar_angle, azimuth_angle,
                  input ready);
  modport sink   (input valid, source_x, source_y, polar_angle, azimuth_angle,
                  output ready);
endinterface

interface rdat_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  hit;
  logic signed [rdat_pkg::LEN_W-1:0]     hit_x;
  logic signed [rdat_pkg::LEN_W-1:0]     hit_y;
  logic signed [rdat_pkg::LEN_W-1:0]     hit_z;
  logic        [rdat_pkg::RAD_W-1:0]     radial_offset;
  logic signed [rdat_pkg::ANG_OUT_W-1:0] offset_angle;
  logic        [rdat_pkg::LEN_W-1:0]     hits_so_far;
  modport source (output valid, hit, hit_x, hit_y, hit_z, radial_offset, offset_angle,
                  hits_so_far, input ready);
  modport sink   (input valid, hit, hit_x, hit_y, hit_z, radial_offset, offset_angle,
                  hits_so_far, output ready);
endinterface

interface rdat_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [rdat_pkg::CFG_IDX_W-1:0]        index;
  logic [rdat_pkg::CFG_DATA_W-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/ray_disc_acceptance_test_unit.sv =====
// Top level: ray and detector disc acceptance test on one shared CORDIC unit.
// One word at a time. A miss outside the bounding square skips the distance compare; a center
// hit or a miss inside it skips the vectoring CORDIC and magnitude scaling; the 32-step divider
// is skipped when the run saturates. The next word is accepted once the result is registered.
// Reset (synchronous, rst_n low) clears the sequencer and hit count, restores the disc defaults.
`default_nettype none
module ray_disc_acceptance_test_unit #(
  parameter int CORDIC_STEPS = rdat_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rdat_in_if.sink     in_ch,
  rdat_out_if.source  out_ch,
  rdat_cfg_if.sink    cfg_ch
);
  import rdat_pkg::*;

  localparam int CW = $clog2(CORDIC_STEPS);
  localparam logic [CW-1:0] LAST_STEP = CW'(CORDIC_STEPS - 1);
  localparam logic [4:0]    DIV_LAST  = 5'd31;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_THI  = 5'd1;
  localparam logic [4:0] ST_THR  = 5'd2;
  localparam logic [4:0] ST_NUM  = 5'd3;
  localparam logic [4:0] ST_DCHK = 5'd4;
  localparam logic [4:0] ST_DIV  = 5'd5;
  localparam logic [4:0] ST_USAT = 5'd6;
  localparam logic [4:0] ST_PHI  = 5'd7;
  localparam logic [4:0] ST_PHR  = 5'd8;
  localparam logic [4:0] ST_MX   = 5'd9;
  localparam logic [4:0] ST_MY   = 5'd10;
  localparam logic [4:0] ST_OFF  = 5'd11;
  localparam logic [4:0] ST_ABS  = 5'd12;
  localparam logic [4:0] ST_BOX  = 5'd13;
  localparam logic [4:0] ST_SQY  = 5'd14;
  localparam logic [4:0] ST_SQR  = 5'd15;
  localparam logic [4:0] ST_CMP  = 5'd16;
  localparam logic [4:0] ST_POR  = 5'd17;
  localparam logic [4:0] ST_MLO  = 5'd18;
  localparam logic [4:0] ST_MHI  = 5'd19;
  localparam logic [4:0] ST_MFN  = 5'd20;
  localparam logic [4:0] ST_FIN  = 5'd21;

  logic [4:0] state_r, state_nxt;

  logic signed [31:0] cx_r, cy_r, height_r;
  logic        [30:0] radius_r;
  logic        [31:0] count_r;

  logic signed [31:0] sx_r, sy_r;
  logic        [31:0] ph_r;
  logic        [31:0] th_r;

  logic signed [45:0] x_r, y_r;
  logic signed [33:0] z_r;
  logic        [CW-1:0] cnt_r;
  logic               flip_r;

  logic signed [32:0] ct_r;
  logic signed [65:0] prod_r;
  logic        [31:0] rem_r, nlo_r, d_r;
  logic        [4:0]  dcnt_r;
  logic               qneg_r;
  logic signed [31:0] u_r;
  logic signed [35:0] px_r, py_r, ox_r, oy_r;
  logic        [63:0] d2_r;
  logic        [45:0] acc_r;
  logic               hit_r;
  logic        [30:0] mag_r;
  logic        [31:0] ang_r;

  logic               out_valid_r;
  logic               out_hit_r;
  logic signed [31:0] out_x_r, out_y_r, out_z_r;
  logic        [30:0] out_mag_r;
  logic        [15:0] out_ang_r;
  logic        [31:0] out_cnt_r;

  // Shared CORDIC rotator.
  logic signed [45:0] xs, ys, nx, ny;
  logic signed [33:0] at, nz;
  logic               polar_mode, rot_pos;
  logic        [4:0]  tab_idx;

  assign polar_mode = (state_r == ST_POR);
  assign tab_idx    = 5'(cnt_r);
  assign xs         = x_r >>> cnt_r;
  assign ys         = y_r >>> cnt_r;
  assign at         = {2'b00, ATAN_TAB[tab_idx]};
  assign rot_pos    = polar_mode ? !(y_r > 46'sd0) : !z_r[33];

  always_comb begin
    if (rot_pos) begin
      nx = x_r - ys;
      ny = y_r + xs;
      nz = z_r - at;
    end else begin
      nx = x_r + ys;
      ny = y_r - xs;
      nz = z_r + at;
    end
  end

  // Angle folding for sin/cos: the two quadrants around a half turn are rotated
  // by a half turn and the result negated.
  logic [31:0] ang_in, ang_fold, ang_off;
  logic        fold;
  assign ang_in   = (state_r == ST_THI) ? th_r : ph_r;
  assign ang_off  = ang_in - 32'h4000_0000;
  assign fold     = (ang_off < 32'h8000_0000);
  assign ang_fold = fold ? (ang_in - 32'h8000_0000) : ang_in;

  logic signed [32:0] cs_x, cs_y;
  assign cs_x = flip_r ? -x_r[32:0] : x_r[32:0];
  assign cs_y = flip_r ? -y_r[32:0] : y_r[32:0];

  // Shared multiplier, product registered.
  logic signed [32:0] mul_a, mul_b;
  logic signed [35:0] ax, ay;
  logic        [45:0] xc;
  assign ax = ox_r[35] ? -ox_r : ox_r;
  assign ay = oy_r[35] ? -oy_r : oy_r;
  assign xc = x_r[45] ? 46'd0 : x_r;

  always_comb begin
    mul_a = 33'sd0;
    mul_b = 33'sd0;
    case (state_r)
      ST_NUM: begin
        mul_a = 33'(height_r);
        mul_b = cs_y;
      end
      ST_MX: begin
        mul_a = 33'(u_r);
        mul_b = cs_x;
      end
      ST_MY: begin
        mul_a = 33'(u_r);
        mul_b = cs_y;
      end
      ST_BOX: begin
        mul_a = ax[32:0];
        mul_b = ax[32:0];
      end
      ST_SQY: begin
        mul_a = ay[32:0];
        mul_b = ay[32:0];
      end
      ST_SQR: begin
        mul_a = {2'b00, radius_r};
        mul_b = {2'b00, radius_r};
      end
      ST_MLO: begin
        mul_a = {10'd0, xc[22:0]};
        mul_b = {11'd0, K22};
      end
      ST_MHI: begin
        mul_a = {10'd0, xc[45:23]};
        mul_b = {11'd0, K22};
      end
      default: ;
    endcase
  end

  // Divider setup.
  logic signed [63:0] num;
  logic        [63:0] n_abs;
  logic        [32:0] d_abs;
  logic               nneg;
  assign num   = prod_r[63:0];
  assign nneg  = num[63];
  assign n_abs = nneg ? 64'(-num) : 64'(num);
  assign d_abs = ct_r[32] ? 33'(-ct_r) : 33'(ct_r);

  logic [32:0] dtry;
  logic        dge;
  assign dtry = {rem_r, nlo_r[31]};
  assign dge  = (dtry >= {1'b0, d_r});

  logic [63:0] d2_sum;
  assign d2_sum = d2_r + prod_r[63:0];

  logic [69:0] msum;
  logic [39:0] mq;
  assign msum = 70'(acc_r) + (70'(prod_r[45:0]) << 23);
  assign mq   = msum[69:30];

  logic [35:0] rad36;
  logic        in_box;
  assign rad36  = {5'd0, radius_r};
  assign in_box = (ax <= $signed(rad36)) && (ay <= $signed(rad36));

  logic [31:0] ang_rnd;
  assign ang_rnd = ang_r + 32'h0000_8000;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      return -32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_ch.valid) state_nxt = ST_THI;
      ST_THI:  state_nxt = ST_THR;
      ST_THR:  if (cnt_r == LAST_STEP) state_nxt = ST_NUM;
      ST_NUM:  state_nxt = ST_DCHK;
      ST_DCHK: begin
        if (ct_r == 33'sd0 || n_abs >= {d_abs[31:0], 32'd0}) begin
          state_nxt = ST_PHI;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV:  if (dcnt_r == DIV_LAST) state_nxt = ST_USAT;
      ST_USAT: state_nxt = ST_PHI;
      ST_PHI:  state_nxt = ST_PHR;
      ST_PHR:  if (cnt_r == LAST_STEP) state_nxt = ST_MX;
      ST_MX:   state_nxt = ST_MY;
      ST_MY:   state_nxt = ST_OFF;
      ST_OFF:  state_nxt = ST_ABS;
      ST_ABS:  state_nxt = ST_BOX;
      ST_BOX:  state_nxt = in_box ? ST_SQY : ST_FIN;
      ST_SQY:  state_nxt = ST_SQR;
      ST_SQR:  state_nxt = ST_CMP;
      ST_CMP: begin
        if (d2_r > prod_r[63:0]) begin
          state_nxt = ST_FIN;
        end else if (ox_r == 36'sd0 && oy_r == 36'sd0) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_POR;
        end
      end
      ST_POR:  if (cnt_r == LAST_STEP) state_nxt = ST_MLO;
      ST_MLO:  state_nxt = ST_MHI;
      ST_MHI:  state_nxt = ST_MFN;
      ST_MFN:  state_nxt = ST_FIN;
      ST_FIN:  if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cx_r        <= 32'sd0;
      cy_r        <= 32'sd0;
      height_r    <= 32'sd65536;
      radius_r    <= 31'd65536;
      count_r     <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_CENTER_X: cx_r     <= cfg_ch.data;
          REG_CENTER_Y: cy_r     <= cfg_ch.data;
          REG_HEIGHT:   height_r <= cfg_ch.data;
          REG_RADIUS:   radius_r <= cfg_ch.data[30:0];
          default: ;
        endcase
      end
      if (state_r == ST_CMP && d2_r <= prod_r[63:0]) begin
        count_r <= count_r + 32'd1;
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_FIN && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      ST_IDLE: begin
        sx_r  <= in_ch.source_x;
        sy_r  <= in_ch.source_y;
        th_r  <= {1'b0, in_ch.polar_angle, 16'd0};
        ph_r  <= {in_ch.azimuth_angle, 16'd0};
        hit_r <= 1'b0;
        mag_r <= 31'd0;
        ang_r <= 32'd0;
      end
      ST_THI, ST_PHI: begin
        x_r    <= 46'(signed'({1'b0, K30}));
        y_r    <= 46'sd0;
        z_r    <= 34'(signed'(ang_fold));
        flip_r <= fold;
        cnt_r  <= '0;
      end
      ST_THR, ST_PHR, ST_POR: begin
        x_r   <= nx;
        y_r   <= ny;
        z_r   <= nz;
        cnt_r <= cnt_r + CW'(1);
      end
      ST_NUM: ct_r <= cs_x;
      ST_DCHK: begin
        qneg_r <= nneg ^ ct_r[32];
        d_r    <= d_abs[31:0];
        rem_r  <= n_abs[63:32];
        nlo_r  <= n_abs[31:0];
        dcnt_r <= 5'd0;
        if (ct_r == 33'sd0) begin
          u_r <= nneg ? -32'sh8000_0000 :
                 (num != 64'sd0 ? 32'sh7FFF_FFFF : 32'sd0);
        end else if (nneg ^ ct_r[32]) begin
          u_r <= -32'sh8000_0000;
        end else begin
          u_r <= 32'sh7FFF_FFFF;
        end
      end
      ST_DIV: begin
        rem_r  <= dge ? 32'(dtry - {1'b0, d_r}) : dtry[31:0];
        nlo_r  <= {nlo_r[30:0], dge};
        dcnt_r <= dcnt_r + 5'd1;
      end
      ST_USAT: begin
        if (qneg_r) begin
          u_r <= (nlo_r > 32'h8000_0000) ? -32'sh8000_0000 : 32'(-nlo_r);
        end else begin
          u_r <= nlo_r[31] ? 32'sh7FFF_FFFF : nlo_r;
        end
      end
      ST_MY:  px_r <= 36'(sx_r) + prod_r[65:30];
      ST_OFF: py_r <= 36'(sy_r) + prod_r[65:30];
      ST_ABS: begin
        ox_r <= px_r - 36'(cx_r);
        oy_r <= py_r - 36'(cy_r);
      end
      ST_SQY: d2_r <= prod_r[63:0];
      ST_SQR: d2_r <= d2_sum;
      ST_CMP: begin
        hit_r <= (d2_r <= prod_r[63:0]);
        cnt_r <= '0;
        // Vectoring starts in the right half plane.
        if (ox_r[35]) begin
          x_r <= -(46'(ox_r) <<< 8);
          y_r <= -(46'(oy_r) <<< 8);
          z_r <= 34'h0_8000_0000;
        end else begin
          x_r <= 46'(ox_r) <<< 8;
          y_r <= 46'(oy_r) <<< 8;
          z_r <= 34'd0;
        end
      end
      ST_MHI: acc_r <= prod_r[45:0];
      ST_MFN: begin
        mag_r <= (mq > 40'h00_7FFF_FFFF) ? 31'h7FFF_FFFF : mq[30:0];
        ang_r <= z_r[31:0];
      end
      default: ;
    endcase
    if (state_r == ST_FIN && (!out_valid_r || out_ch.ready)) begin
      out_hit_r <= hit_r;
      out_x_r   <= hit_r ? sat32(px_r) : 32'sd0;
      out_y_r   <= hit_r ? sat32(py_r) : 32'sd0;
      out_z_r   <= hit_r ? height_r : 32'sd0;
      out_mag_r <= hit_r ? mag_r : 31'd0;
      out_ang_r <= hit_r ? ang_rnd[31:16] : 16'd0;
      out_cnt_r <= count_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.hit           = out_hit_r;
  assign out_ch.hit_x         = out_x_r;
  assign out_ch.hit_y         = out_y_r;
  assign out_ch.hit_z         = out_z_r;
  assign out_ch.radial_offset = out_mag_r;
  assign out_ch.offset_angle  = out_ang_r;
  assign out_ch.hits_so_far   = out_cnt_r;

endmodule
`default_nettype wire

// ===== test/ray_disc_acceptance_test_unit_tb.sv =====
// Self-checking testbench for the ray and detector disc acceptance test unit.
`timescale 1ns / 1ps
module ray_disc_acceptance_test_unit_tb;
  import rdat_pkg::*;

  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int SETTLE_CYCLES = 3 * STEPS + 80;
  localparam int WATCHDOG_LIMIT = 40000;

  // Register indexes past the end of the list.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
    logic [30:0]        radial_offset;
    logic signed [15:0] offset_angle;
    logic [31:0]        hits_so_far;
  } ray_result_t;

  logic clk;
  logic rst_n;
  rdat_in_if  in_ch ();
  rdat_out_if out_ch ();
  rdat_cfg_if cfg_ch ();

  ray_disc_acceptance_test_unit #(.CORDIC_STEPS(STEPS)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // Shadow copy of the disc setup and the hit count.
  logic signed [63:0] center_x_m, center_y_m, height_m, radius_m;
  logic [31:0] hit_count_m;

  ray_result_t expected_q[$];
  int  error_count;
  int  idle_cycles;
  bit  calm;      // when set, neither side idles
  bit  timed_out;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [63:0] shr_floor(logic signed [63:0] v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Rotation mode: angle with a full turn of 2^32, outputs in Q2.30.
  task automatic rotate_angle(input logic [31:0] a, output logic signed [63:0] c,
                              output logic signed [63:0] s);
    logic signed [63:0] x, y, z, nx;
    bit flip;
    logic [31:0] d;
    x = K30;
    y = 0;
    flip = 0;
    d = a - 32'h4000_0000;
    if (d < 32'h8000_0000) begin
      a = a - 32'h8000_0000;
      flip = 1;
    end
    z = $signed(a);
    for (int i = 0; i < STEPS && i < TAB_LEN; i++) begin
      if (z >= 0) begin
        nx = x - shr_floor(y, i); y = y + shr_floor(x, i); z = z - ATAN_TAB[i];
      end else begin
        nx = x + shr_floor(y, i); y = y - shr_floor(x, i); z = z + ATAN_TAB[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // Vectoring mode: magnitude in Q16.16 and angle with a full turn of 2^32.
  task automatic polar_of(input logic signed [63:0] ox, input logic signed [63:0] oy,
                          output logic [30:0] mag, output logic [31:0] ang);
    logic signed [63:0] x, y, nx;
    logic [31:0] z;
    logic [63:0] m;
    x = ox * 256;
    y = oy * 256;
    z = 0;
    if (ox == 0 && oy == 0) begin
      mag = 0;
      ang = 0;
      return;
    end
    if (x < 0) begin
      x = -x; y = -y; z = 32'h8000_0000;
    end
    for (int i = 0; i < STEPS && i < TAB_LEN; i++) begin
      if (y > 0) begin
        nx = x + shr_floor(y, i); y = y - shr_floor(x, i); z = z + ATAN_TAB[i];
      end else begin
        nx = x - shr_floor(y, i); y = y + shr_floor(x, i); z = z - ATAN_TAB[i];
      end
      x = nx;
    end
    if (x < 0) x = 0;
    m = (64'(x) * 64'(K22)) >> 30;
    mag = (m > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : m[30:0];
    ang = z;
  endtask

  task automatic predict_hit(input logic signed [31:0] sx, input logic signed [31:0] sy,
                             input logic [14:0] th, input logic [15:0] ph,
                             output ray_result_t r);
    logic signed [63:0] ct, st, cp, sp, num, run, px, py, ox, oy, ax, ay;
    logic [63:0] d2, r2;
    logic [30:0] mag;
    logic [31:0] ang, rounded;
    bit hit;
    rotate_angle({th, 16'h0}, ct, st);
    num = height_m * st;
    if (ct == 0) run = num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
    else run = clamp32(num / ct);
    rotate_angle({ph, 16'h0}, cp, sp);
    px = sx + shr_floor(run * cp, 30);
    py = sy + shr_floor(run * sp, 30);
    ox = px - center_x_m;
    oy = py - center_y_m;
    ax = ox < 0 ? -ox : ox;
    ay = oy < 0 ? -oy : oy;
    hit = 0;
    if (ax <= radius_m && ay <= radius_m) begin
      d2 = ax * ax + ay * ay;
      r2 = radius_m * radius_m;
      hit = d2 <= r2;
    end
    r = '0;
    if (hit) begin
      hit_count_m = hit_count_m + 1;
      polar_of(ox, oy, mag, ang);
      r.hit = 1;
      r.hit_x = 32'(clamp32(px));
      r.hit_y = 32'(clamp32(py));
      r.hit_z = height_m[31:0];
      r.radial_offset = mag;
      rounded = (ang + 32'h8000) >> 16;
      r.offset_angle = rounded[15:0];
    end
    r.hits_so_far = hit_count_m;
  endtask

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 15);
  endfunction

  // Valid stays high after the accepting edge; the next call or a drain lowers it.
  task automatic send_ray(input logic [31:0] sx, input logic [31:0] sy,
                          input logic [14:0] th, input logic [15:0] ph);
    ray_result_t r;
    while (idle_now()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    predict_hit(sx, sy, th, ph, r);
    expected_q.push_back(r);
    in_ch.valid <= 1'b1;
    in_ch.source_x <= sx;
    in_ch.source_y <= sy;
    in_ch.polar_angle <= th;
    in_ch.azimuth_angle <= ph;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Valid stays high after the accepting edge; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_CENTER_X: center_x_m = $signed(value);
      REG_CENTER_Y: center_y_m = $signed(value);
      REG_HEIGHT:   height_m = $signed(value);
      REG_RADIUS:   radius_m = {33'd0, value[30:0]};
      default: ;
    endcase
  endtask

  task automatic set_disc(input logic [31:0] cx, input logic [31:0] cy,
                          input logic [31:0] h, input logic [31:0] rad);
    drain_results();
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_RADIUS, rad);
    cfg_ch.valid <= 1'b0;
  endtask

  // A ray aimed near the disc: source close to the centre, shallow polar angle.
  task automatic send_aimed_ray();
    logic [31:0] jx, jy;
    jx = center_x_m[31:0] + $signed($urandom_range(2 * 65536) - 65536);
    jy = center_y_m[31:0] + $signed($urandom_range(2 * 65536) - 65536);
    send_ray(jx, jy, 15'($urandom_range(3000) + ($urandom_range(1) ? 15'd29768 : 15'd0)),
             16'($urandom));
  endtask

  task automatic test_directed_extremes();
    set_disc(32'd0, 32'd0, 32'd65536, 32'd65536);
    send_ray(0, 0, 0, 0);                       // straight up, dead centre
    send_ray(0, 0, 15'd16384, 0);               // theta at a right angle
    send_ray(0, 0, 15'h7FFF, 16'hFFFF);
    send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
    send_ray(32'h8000_0000, 32'h8000_0000, 15'h7FFF, 16'h8000);
    send_ray(32'd65536, 0, 0, 0);               // exactly on the rim
    send_ray(32'd65537, 0, 0, 0);               // just outside
    send_ray(32'hFFFF_0000, 0, 0, 16'h4000);
    send_ray(0, 32'd65536, 0, 16'hC000);
    send_ray(0, 0, 15'd2048, 16'd8192);
    send_ray(0, 0, 15'd30720, 16'd24576);       // theta past a right angle
    send_ray(32'h5555_5555, 32'hAAAA_AAAA, 15'h5555, 16'hAAAA);
  endtask

  task automatic test_zero_radius_and_negative_height();
    set_disc(32'd0, 32'd0, 32'd65536, 32'd0);
    send_ray(0, 0, 0, 0);                       // zero offset on a point disc
    send_ray(1, 0, 0, 0);
    set_disc(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_ray(32'h8000_0000, 32'h7FFF_FFFF, 15'd100, 16'd1234);
    send_ray(0, 0, 15'd16000, 16'hFFFF);
    set_disc(32'hFFF0_0000, 32'h0010_0000, 32'hFFFF_0000, 32'h0002_0000);
    send_ray(32'hFFF0_0000, 32'h0010_0000, 15'd1000, 16'd3000);
    send_ray(32'hFFF0_0000, 32'h0010_0000, 15'd31767, 16'd60000);
    set_disc(32'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_ray(0, 0, 15'd16383, 16'd100);         // huge run that saturates
  endtask

  task automatic test_random_rays(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 0) begin
        logic [31:0] rad;
        rad = ($urandom_range(9) == 0) ? $urandom : $urandom_range(32'h0008_0000, 32'h100);
        set_disc($urandom_range(1) ? $urandom : $urandom_range(32'h0010_0000),
                 $urandom_range(1) ? $urandom : $urandom_range(32'h0010_0000),
                 $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0004_0000, 1),
                 rad);
      end
      calm = (n >= 600 && n < 800);
      if ($urandom_range(9) < 7) send_aimed_ray();
      else send_ray($urandom, $urandom, 15'($urandom), 16'($urandom));
    end
    calm = 0;
  endtask

  task automatic test_pause_until_drained();
    set_disc(32'd0, 32'd0, 32'd65536, 32'd65536);
    send_ray(0, 0, 0, 0);
    drain_results();
    send_ray(32'd1000, 32'd2000, 15'd500, 16'd700);
    // Configuration indexes past the list must have no effect.
    drain_results();
    write_reg(REG_UNUSED_LO, 32'hDEAD_BEEF);
    write_reg(REG_UNUSED_HI, 32'h1234_5678);
    cfg_ch.valid <= 1'b0;
    send_ray(0, 32'd100, 0, 0);
  endtask

  // Result checker.
  always @(posedge clk) begin
    ray_result_t got, want;
    if (rst_n) begin
      if (!calm) out_ch.ready <= ($urandom_range(99) >= 15);
      else out_ch.ready <= 1'b1;
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.hit, out_ch.hit_x, out_ch.hit_y, out_ch.hit_z,
                out_ch.radial_offset, out_ch.offset_angle, out_ch.hits_so_far};
        if (expected_q.size() == 0) begin
          $display("%0t: result word with nothing expected: %p", $time, got);
          error_count++;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog over cycles with no accepted word on any channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    idle_cycles = 0;
    calm = 0;
    timed_out = 0;
    center_x_m = 0;
    center_y_m = 0;
    height_m = 65536;
    radius_m = 65536;
    hit_count_m = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.source_x = '0;
    in_ch.source_y = '0;
    in_ch.polar_angle = '0;
    in_ch.azimuth_angle = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_zero_radius_and_negative_height();
    test_pause_until_drained();
    test_random_rays(1820);
    drain_results();
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/rdat_pkg.sv
rtl/rdat_ifs.sv
rtl/ray_disc_acceptance_test_unit.sv
test/ray_disc_acceptance_test_unit_tb.sv
